### hdl/ray_triangle_nearest_hit_unit_assert.svh
// Assertion macros used by the nearest hit unit's top-level RTL file.
`ifndef RAY_TRIANGLE_NEAREST_HIT_UNIT_ASSERT_SVH
`define RAY_TRIANGLE_NEAREST_HIT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RTNH_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define RTNH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/rtnh_pkg.sv
// Types, constants and helpers of the ray/triangle nearest hit unit.
package rtnh_pkg;

   // Fixed-point setup
   localparam int FRAC_BITS     = 8;
   localparam int DET_UNIT_BITS = 24;
   localparam int MAX_TRIANGLES = 65536;
   localparam int SCALE_BITS    = 3 * FRAC_BITS;
   localparam int DET_UP = (SCALE_BITS >= DET_UNIT_BITS) ? SCALE_BITS - DET_UNIT_BITS : 0;
   localparam int DET_DN = (SCALE_BITS >= DET_UNIT_BITS) ? 0 : DET_UNIT_BITS - SCALE_BITS;
   localparam logic [24:0] CNT_WRAP = 25'(MAX_TRIANGLES);

   // Datapath widths
   localparam int OP_A_W = 35;
   localparam int OP_B_W = 31;
   localparam int PROD_W = OP_A_W + OP_B_W;
   localparam int ACC_W  = 64;
   localparam int GEO_W  = 52;
   localparam int CRS_W  = 34;
   localparam int NRM_W  = 43;
   localparam int MAG_W  = 42;
   localparam int DIV_W  = 56;

   typedef enum logic [1:0] {
      CSR_RAY_ORIGIN,
      CSR_RAY_DIRECTION,
      CSR_MAX_DISTANCE,
      CSR_MIN_DETERMINANT
   } csr_index_type;

   typedef struct packed {
      logic        last_triangle;
      logic [47:0] normal_two;
      logic [47:0] normal_one;
      logic [47:0] normal_zero;
      logic [47:0] vertex_two;
      logic [47:0] vertex_one;
      logic [47:0] vertex_zero;
   } req_type;

   typedef struct packed {
      logic        done_res;
      logic [15:0] hit_index;
      logic [47:0] hit_normal;
      logic [47:0] hit_point;
      logic [31:0] hit_distance;
      logic        hit;
   } rsp_type;

   typedef enum logic [4:0] {
      DST_P0, DST_P1, DST_P2,
      DST_Q0, DST_Q1, DST_Q2,
      DST_A, DST_U, DST_V, DST_T,
      DST_C0, DST_C1, DST_C2,
      DST_PT0, DST_PT1, DST_PT2,
      DST_L2
   } dest_type;

   // Tag that travels with a product through the multiplier
   typedef struct packed {
      logic     valid;
      logic     first;
      logic     last;
      logic     neg;
      dest_type dest;
   } mul_tag_type;

   typedef enum logic {
      MODE_DIV,
      MODE_SQRT
   } div_mode_type;

   typedef struct packed {
      logic              start;
      div_mode_type      mode;
      logic [DIV_W-1:0]  r_init;
      logic [63:0]       lo;
      logic [DIV_W-1:0]  divisor;
      logic [5:0]        steps;
   } div_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GEOM,
      ST_CHECK,
      ST_DIVT,
      ST_WAITT,
      ST_SELECT,
      ST_POINT,
      ST_WSHIFT,
      ST_NMUL,
      ST_MSHIFT,
      ST_LEN,
      ST_SQRT,
      ST_WAITS,
      ST_DIVN,
      ST_WAITN,
      ST_END
   } state_type;

   // Cull threshold on the determinant's scale, rounded up when coarser
   function automatic logic [63:0] cull_threshold(input logic [15:0] m);
      logic [63:0] wide;
      wide = {48'b0, m};
      if (SCALE_BITS >= DET_UNIT_BITS)
         return wide << DET_UP;
      else
         return (wide + ((64'd1 << DET_DN) - 64'd1)) >> DET_DN;
   endfunction

   // Signed component i of a packed vector
   function automatic logic signed [15:0] comp(input logic [47:0] w, input logic [1:0] i);
      return signed'(w[16*i +: 16]);
   endfunction

endpackage

### hdl/rtnh_mul.sv
// Shared signed multiplier with a registered product and tag.
module rtnh_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [rtnh_pkg::OP_A_W-1:0]   op_a,
   input  logic signed [rtnh_pkg::OP_B_W-1:0]   op_b,
   input  rtnh_pkg::mul_tag_type                tag_in,
   output logic signed [rtnh_pkg::PROD_W-1:0]   prod_ff,
   output rtnh_pkg::mul_tag_type                tag_ff
);
   import rtnh_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   // Form the full product
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // Register product and tag
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

endmodule

### hdl/rtnh_divsqrt.sv
// Shared restoring divide and digit-by-digit square root, one bit per cycle.
module rtnh_divsqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  rtnh_pkg::div_cmd_type cmd,
   output rtnh_pkg::div_stat_type stat
);
   import rtnh_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   div_mode_type     mode_ff, mode_in;
   logic [DIV_W-1:0] r_ff, r_in;
   logic [DIV_W-1:0] d_ff, d_in;
   logic [63:0]      lo_ff, lo_in;
   logic [31:0]      q_ff, q_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [DIV_W-1:0] x_op, y_op;
   logic [DIV_W:0]   diff;
   logic             ge;

   // Pick trial operands for the current mode
   always_comb begin
      if (mode_ff == MODE_DIV) begin
         x_op = {r_ff[DIV_W-2:0], lo_ff[63]};
         y_op = d_ff;
      end else begin
         x_op = {r_ff[DIV_W-3:0], lo_ff[63:62]};
         y_op = {22'b0, q_ff, 2'b01};
      end
      diff = {1'b0, x_op} - {1'b0, y_op};
      ge   = !diff[DIV_W];
   end

   // Load on start, then retire one quotient or root bit a cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.mode;
         r_in    = cmd.r_init;
         d_in    = cmd.divisor;
         lo_in   = cmd.lo;
         q_in    = '0;
         cnt_in  = cmd.steps;
      end else if (busy_ff) begin
         r_in   = ge ? diff[DIV_W-1:0] : x_op;
         q_in   = {q_ff[30:0], ge};
         lo_in  = (mode_ff == MODE_DIV) ? {lo_ff[62:0], 1'b0} : {lo_ff[61:0], 2'b00};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      lo_ff   <= lo_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = q_ff;

endmodule

### hdl/ray_triangle_nearest_hit_unit.sv
// Nearest ray/triangle hit over a streamed mesh: sequencer, registers and top level.
// One triangle is taken at a time and req_stall stays high until it is finished.
// A triangle that is culled or fails the range tests runs the 24-step product
// program on the single shared multiplier (cross products and dot products for
// the determinant and the three numerators), then its last landing, the checks
// and the counter update before the next possible accept. A hit that is not nearer
// adds a divide for the distance unless the distance saturates. An accepted nearer
// hit also needs the hit point and weighted normal products on the same multiplier,
// one-bit scaling shifts, a square root and, unless the length is zero, three
// divides for the unit normal. The divides and the root run on the shared
// divide/root unit. A result beat is produced only on the mesh's last triangle. It
// sits in an output register, and the next triangle is taken while it waits.
module ray_triangle_nearest_hit_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rtnh_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rtnh_pkg::rsp_type       rsp_data,
   input  logic                    csr_write,
   input  rtnh_pkg::csr_index_type csr_index,
   input  logic [47:0]             csr_data
);
   import rtnh_pkg::*;
`include "ray_triangle_nearest_hit_unit_assert.svh"

   // Configuration
   logic [47:0] origin_ff, origin_in;
   logic [47:0] direction_ff, direction_in;
   logic [31:0] max_dist_ff, max_dist_in;
   logic [15:0] min_det_ff, min_det_in;

   // Sequencer
   state_type   state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic [1:0]  comp_ff, comp_in;

   // Triangle operands
   logic signed [16:0]      e1_ff [3], e1_in [3];
   logic signed [16:0]      e2_ff [3], e2_in [3];
   logic signed [16:0]      s_ff [3], s_in [3];
   logic signed [15:0]      n_ff [3][3], n_in [3][3];
   logic                    last_ff, last_in;

   // Intermediate results
   logic signed [CRS_W-1:0] p_ff [3], p_in [3];
   logic signed [CRS_W-1:0] q_ff [3], q_in [3];
   logic signed [GEO_W-1:0] a_ff, a_in, u_ff, u_in, v_ff, v_in, t_ff, t_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [31:0]             tq_ff, tq_in;
   logic [GEO_W-1:0]        w_ff [3], w_in [3];
   logic [GEO_W-1:0]        aa_ff, aa_in;
   logic [MAG_W-1:0]        mag_ff [3], mag_in [3];
   logic                    neg_ff [3], neg_in [3];
   logic [61:0]             len2_ff, len2_in;
   logic [31:0]             len_ff, len_in;

   // Search state
   logic [31:0] best_dist_ff, best_dist_in;
   logic        found_ff, found_in;
   logic [47:0] best_point_ff, best_point_in;
   logic [47:0] best_normal_ff, best_normal_in;
   logic [15:0] best_tri_ff, best_tri_in;
   logic [15:0] count_ff, count_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Shared units
   logic signed [OP_A_W-1:0] op_a;
   logic signed [OP_B_W-1:0] op_b;
   mul_tag_type              tag_issue, tag_done;
   logic signed [PROD_W-1:0] prod;
   div_cmd_type              div_cmd;
   div_stat_type             div_stat;

   // Scratch
   logic signed [15:0]       o_w [3], d_w [3], v0_w [3], v1_w [3], v2_w [3];
   logic signed [ACC_W-1:0]  acc_base, acc_sum, prod64, pv;
   logic signed [NRM_W-1:0]  cval;
   logic [63:0]              thr;
   logic [16:0]              count_next;
   logic [45:0]              nnum;
   logic [14:0]              nmag;
   logic [15:0]              nres;
   logic [1:0]               k2;
   logic [1:0]               wb_k;

   rtnh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .op_a    (op_a),
      .op_b    (op_b),
      .tag_in  (tag_issue),
      .prod_ff (prod),
      .tag_ff  (tag_done)
   );

   rtnh_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // Unpack ray and vertices
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_w[i]  = comp(origin_ff, 2'(i));
         d_w[i]  = comp(direction_ff, 2'(i));
         v0_w[i] = comp(req_data.vertex_zero, 2'(i));
         v1_w[i] = comp(req_data.vertex_one, 2'(i));
         v2_w[i] = comp(req_data.vertex_two, 2'(i));
      end
   end

   // Issue program of the shared multiplier
   always_comb begin
      op_a      = '0;
      op_b      = '0;
      tag_issue = '0;
      k2        = '0;
      unique case (state_ff)
         ST_GEOM: begin
            tag_issue.valid = (step_ff <= 5'd23);
            case (step_ff)
               5'd0: begin op_a = OP_A_W'(e2_ff[2]); op_b = OP_B_W'(d_w[1]);
                  tag_issue.first = 1'b1; end
               5'd1: begin op_a = OP_A_W'(e2_ff[1]); op_b = OP_B_W'(d_w[2]);
                  tag_issue.last = 1'b1; tag_issue.neg = 1'b1; tag_issue.dest = DST_P0; end
               5'd2: begin op_a = OP_A_W'(e2_ff[0]); op_b = OP_B_W'(d_w[2]);
                  tag_issue.first = 1'b1; end
               5'd3: begin op_a = OP_A_W'(e2_ff[2]); op_b = OP_B_W'(d_w[0]);
                  tag_issue.last = 1'b1; tag_issue.neg = 1'b1; tag_issue.dest = DST_P1; end
               5'd4: begin op_a = OP_A_W'(e2_ff[1]); op_b = OP_B_W'(d_w[0]);
                  tag_issue.first = 1'b1; end
               5'd5: begin op_a = OP_A_W'(e2_ff[0]); op_b = OP_B_W'(d_w[1]);
                  tag_issue.last = 1'b1; tag_issue.neg = 1'b1; tag_issue.dest = DST_P2; end
               5'd6: begin op_a = OP_A_W'(e1_ff[2]); op_b = OP_B_W'(s_ff[1]);
                  tag_issue.first = 1'b1; end
               5'd7: begin op_a = OP_A_W'(e1_ff[1]); op_b = OP_B_W'(s_ff[2]);
                  tag_issue.last = 1'b1; tag_issue.neg = 1'b1; tag_issue.dest = DST_Q0; end
               5'd8: begin op_a = OP_A_W'(e1_ff[0]); op_b = OP_B_W'(s_ff[2]);
                  tag_issue.first = 1'b1; end
               5'd9: begin op_a = OP_A_W'(e1_ff[2]); op_b = OP_B_W'(s_ff[0]);
                  tag_issue.last = 1'b1; tag_issue.neg = 1'b1; tag_issue.dest = DST_Q1; end
               5'd10: begin op_a = OP_A_W'(e1_ff[1]); op_b = OP_B_W'(s_ff[0]);
                  tag_issue.first = 1'b1; end
               5'd11: begin op_a = OP_A_W'(e1_ff[0]); op_b = OP_B_W'(s_ff[1]);
                  tag_issue.last = 1'b1; tag_issue.neg = 1'b1; tag_issue.dest = DST_Q2; end
               5'd12, 5'd13, 5'd14: begin
                  k2 = 2'(step_ff - 5'd12);
                  op_a = OP_A_W'(p_ff[k2]); op_b = OP_B_W'(e1_ff[k2]);
                  tag_issue.first = (k2 == 2'd0); tag_issue.last = (k2 == 2'd2);
                  tag_issue.dest = DST_A;
               end
               5'd15, 5'd16, 5'd17: begin
                  k2 = 2'(step_ff - 5'd15);
                  op_a = OP_A_W'(p_ff[k2]); op_b = OP_B_W'(s_ff[k2]);
                  tag_issue.first = (k2 == 2'd0); tag_issue.last = (k2 == 2'd2);
                  tag_issue.dest = DST_U;
               end
               5'd18, 5'd19, 5'd20: begin
                  k2 = 2'(step_ff - 5'd18);
                  op_a = OP_A_W'(q_ff[k2]); op_b = OP_B_W'(d_w[k2]);
                  tag_issue.first = (k2 == 2'd0); tag_issue.last = (k2 == 2'd2);
                  tag_issue.dest = DST_V;
               end
               5'd21, 5'd22, 5'd23: begin
                  k2 = 2'(step_ff - 5'd21);
                  op_a = OP_A_W'(q_ff[k2]); op_b = OP_B_W'(e2_ff[k2]);
                  tag_issue.first = (k2 == 2'd0); tag_issue.last = (k2 == 2'd2);
                  tag_issue.dest = DST_T;
               end
               default: ;
            endcase
         end
         ST_POINT: begin
            if (step_ff <= 5'd2) begin
               k2 = step_ff[1:0];
               op_a = OP_A_W'({3'b0, tq_ff});
               op_b = OP_B_W'(d_w[k2]);
               tag_issue = '{valid: 1'b1, first: 1'b1, last: 1'b1, neg: 1'b0,
                             dest: dest_type'(DST_PT0 + k2)};
            end
         end
         ST_NMUL: begin
            if (step_ff <= 5'd8) begin
               // Component step/3, weight step%3
               case (step_ff)
                  5'd0, 5'd1, 5'd2: begin
                     k2 = 2'(step_ff);
                     op_b = OP_B_W'(n_ff[k2][0]); tag_issue.dest = DST_C0;
                  end
                  5'd3, 5'd4, 5'd5: begin
                     k2 = 2'(step_ff - 5'd3);
                     op_b = OP_B_W'(n_ff[k2][1]); tag_issue.dest = DST_C1;
                  end
                  default: begin
                     k2 = 2'(step_ff - 5'd6);
                     op_b = OP_B_W'(n_ff[k2][2]); tag_issue.dest = DST_C2;
                  end
               endcase
               op_a = OP_A_W'({11'b0, w_ff[k2][23:0]});
               tag_issue.valid = 1'b1;
               tag_issue.first = (k2 == 2'd0);
               tag_issue.last  = (k2 == 2'd2);
            end
         end
         ST_LEN: begin
            if (step_ff <= 5'd2) begin
               k2 = step_ff[1:0];
               op_a = OP_A_W'({5'b0, mag_ff[k2][29:0]});
               op_b = OP_B_W'({1'b0, mag_ff[k2][29:0]});
               tag_issue = '{valid: 1'b1, first: (k2 == 2'd0), last: (k2 == 2'd2),
                             neg: 1'b0, dest: DST_L2};
            end
         end
         default: ;
      endcase
   end

   // Accumulate landing products
   always_comb begin
      prod64   = prod[ACC_W-1:0];
      acc_base = tag_done.first ? '0 : acc_ff;
      acc_sum  = tag_done.neg ? acc_base - prod64 : acc_base + prod64;
      cval     = acc_sum[NRM_W-1:0];
      pv       = (acc_sum >>> 16) + ACC_W'(o_w[tag_done.dest == DST_PT0 ? 0 :
                                              tag_done.dest == DST_PT1 ? 1 : 2]);
   end

   // Sequencer and datapath next values
   always_comb begin
      origin_in      = origin_ff;
      direction_in   = direction_ff;
      max_dist_in    = max_dist_ff;
      min_det_in     = min_det_ff;
      state_in       = state_ff;
      step_in        = step_ff;
      comp_in        = comp_ff;
      e1_in          = e1_ff;
      e2_in          = e2_ff;
      s_in           = s_ff;
      n_in           = n_ff;
      last_in        = last_ff;
      p_in           = p_ff;
      q_in           = q_ff;
      a_in           = a_ff;
      u_in           = u_ff;
      v_in           = v_ff;
      t_in           = t_ff;
      acc_in         = acc_ff;
      tq_in          = tq_ff;
      w_in           = w_ff;
      aa_in          = aa_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      len2_in        = len2_ff;
      len_in         = len_ff;
      best_dist_in   = best_dist_ff;
      found_in       = found_ff;
      best_point_in  = best_point_ff;
      best_normal_in = best_normal_ff;
      best_tri_in    = best_tri_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      div_cmd        = '0;
      wb_k           = '0;
      thr            = cull_threshold(min_det_ff);
      count_next     = {1'b0, count_ff} + 17'd1;
      nnum           = 46'({mag_ff[comp_ff][29:0], 15'b0}) + 46'(len_ff);
      nmag           = (div_stat.quotient[15:0] > 16'd16384) ? 15'd16384
                                                             : div_stat.quotient[14:0];
      nres           = neg_ff[comp_ff] ? -{1'b0, nmag} : {1'b0, nmag};

      // Configuration writes
      if (csr_write) begin
         unique case (csr_index)
            CSR_RAY_ORIGIN:      origin_in = csr_data;
            CSR_RAY_DIRECTION:   direction_in = csr_data;
            CSR_MAX_DISTANCE: begin
               max_dist_in = csr_data[31:0];
               if (count_ff == 16'd0) best_dist_in = csr_data[31:0];
            end
            CSR_MIN_DETERMINANT: min_det_in = csr_data[15:0];
         endcase
      end

      // Write back finished accumulations
      if (tag_done.valid) begin
         acc_in = acc_sum;
         if (tag_done.last) begin
            case (tag_done.dest)
               DST_P0: p_in[0] = acc_sum[CRS_W-1:0];
               DST_P1: p_in[1] = acc_sum[CRS_W-1:0];
               DST_P2: p_in[2] = acc_sum[CRS_W-1:0];
               DST_Q0: q_in[0] = acc_sum[CRS_W-1:0];
               DST_Q1: q_in[1] = acc_sum[CRS_W-1:0];
               DST_Q2: q_in[2] = acc_sum[CRS_W-1:0];
               DST_A:  a_in = acc_sum[GEO_W-1:0];
               DST_U:  u_in = acc_sum[GEO_W-1:0];
               DST_V:  v_in = acc_sum[GEO_W-1:0];
               DST_T:  t_in = acc_sum[GEO_W-1:0];
               DST_C0, DST_C1, DST_C2: begin
                  wb_k = 2'(tag_done.dest - DST_C0);
                  neg_in[wb_k] = cval < 0;
                  mag_in[wb_k] = (cval < 0) ? MAG_W'(-cval) : MAG_W'(cval);
               end
               DST_PT0, DST_PT1, DST_PT2: begin
                  wb_k = 2'(tag_done.dest - DST_PT0);
                  if (pv > 64'sd32767)       best_point_in[16*wb_k +: 16] = 16'h7fff;
                  else if (pv < -64'sd32768) best_point_in[16*wb_k +: 16] = 16'h8000;
                  else                       best_point_in[16*wb_k +: 16] = pv[15:0];
               end
               DST_L2: len2_in = acc_sum[61:0];
               default: ;
            endcase
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Take a triangle beat, form edges and origin offset
            if (req_valid) begin
               for (int i = 0; i < 3; i++) begin
                  e1_in[i] = 17'(v1_w[i]) - 17'(v0_w[i]);
                  e2_in[i] = 17'(v2_w[i]) - 17'(v0_w[i]);
                  s_in[i]  = 17'(o_w[i]) - 17'(v0_w[i]);
                  n_in[0][i] = comp(req_data.normal_zero, 2'(i));
                  n_in[1][i] = comp(req_data.normal_one, 2'(i));
                  n_in[2][i] = comp(req_data.normal_two, 2'(i));
               end
               last_in  = req_data.last_triangle;
               step_in  = '0;
               state_in = ST_GEOM;
            end
         end
         ST_GEOM: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd24) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // Cull and barycentric range tests
            if (a_ff > 0 && {12'b0, a_ff} >= thr && u_ff >= 0 && u_ff <= a_ff &&
                v_ff >= 0 && (u_ff + v_ff) <= a_ff && t_ff > 0)
               state_in = ST_DIVT;
            else
               state_in = ST_END;
         end
         ST_DIVT: begin
            if ({16'b0, t_ff} >= {a_ff, 16'b0}) begin
               tq_in    = 32'hffff_ffff;
               state_in = ST_SELECT;
            end else begin
               div_cmd.start   = 1'b1;
               div_cmd.mode    = MODE_DIV;
               div_cmd.r_init  = DIV_W'(t_ff[GEO_W-1:16]);
               div_cmd.lo      = {t_ff[15:0], 48'b0};
               div_cmd.divisor = DIV_W'(a_ff);
               div_cmd.steps   = 6'd32;
               state_in        = ST_WAITT;
            end
         end
         ST_WAITT: begin
            if (div_stat.done) begin
               tq_in    = div_stat.quotient;
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            // Keep only a strictly nearer hit
            if (tq_ff < best_dist_ff) begin
               best_dist_in = tq_ff;
               found_in     = 1'b1;
               best_tri_in  = count_ff;
               w_in[0]      = a_ff - u_ff - v_ff;
               w_in[1]      = u_ff;
               w_in[2]      = v_ff;
               aa_in        = a_ff;
               step_in      = '0;
               state_in     = ST_POINT;
            end else begin
               state_in = ST_END;
            end
         end
         ST_POINT: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd3) state_in = ST_WSHIFT;
         end
         ST_WSHIFT: begin
            // Scale weights until the determinant fits 24 bits
            if (aa_ff[GEO_W-1:24] != '0) begin
               aa_in = aa_ff >> 1;
               for (int i = 0; i < 3; i++) w_in[i] = w_ff[i] >> 1;
            end else begin
               step_in  = '0;
               state_in = ST_NMUL;
            end
         end
         ST_NMUL: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd9) state_in = ST_MSHIFT;
         end
         ST_MSHIFT: begin
            // Scale magnitudes until all fit 30 bits
            if (mag_ff[0][MAG_W-1:30] != '0 || mag_ff[1][MAG_W-1:30] != '0 ||
                mag_ff[2][MAG_W-1:30] != '0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else begin
               step_in  = '0;
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd3) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            div_cmd.start = 1'b1;
            div_cmd.mode  = MODE_SQRT;
            div_cmd.lo    = {2'b0, len2_ff};
            div_cmd.steps = 6'd32;
            state_in      = ST_WAITS;
         end
         ST_WAITS: begin
            if (div_stat.done) begin
               len_in  = div_stat.quotient;
               comp_in = '0;
               if (div_stat.quotient == 32'd0) begin
                  best_normal_in = '0;
                  state_in       = ST_END;
               end else begin
                  state_in = ST_DIVN;
               end
            end
         end
         ST_DIVN: begin
            // Rounded divide of one component by the length
            div_cmd.start   = 1'b1;
            div_cmd.mode    = MODE_DIV;
            div_cmd.r_init  = DIV_W'(nnum[45:16]);
            div_cmd.lo      = {nnum[15:0], 48'b0};
            div_cmd.divisor = DIV_W'({len_ff, 1'b0});
            div_cmd.steps   = 6'd16;
            state_in        = ST_WAITN;
         end
         ST_WAITN: begin
            if (div_stat.done) begin
               best_normal_in[16*comp_ff +: 16] = nres;
               comp_in = comp_ff + 2'd1;
               state_in = (comp_ff == 2'd2) ? ST_END : ST_DIVN;
            end
         end
         ST_END: begin
            // Advance the counter; on the last triangle emit the beat and reload
            if (!last_ff || !rsp_valid_ff || !rsp_stall) begin
               count_in = ({8'b0, count_next} >= CNT_WRAP) ? 16'd0 : count_next[15:0];
               if (last_ff) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.hit          = found_ff;
                  rsp_in.hit_distance = found_ff ? best_dist_ff : '0;
                  rsp_in.hit_point    = found_ff ? best_point_ff : '0;
                  rsp_in.hit_normal   = found_ff ? best_normal_ff : '0;
                  rsp_in.hit_index    = found_ff ? best_tri_ff : '0;
                  rsp_in.done_res     = 1'b1;
                  best_dist_in        = max_dist_ff;
                  found_in            = 1'b0;
                  best_point_in       = '0;
                  best_normal_in      = '0;
                  best_tri_in         = '0;
                  count_in            = '0;
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      s_ff    <= s_in;
      n_ff    <= n_in;
      last_ff <= last_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      a_ff    <= a_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      t_ff    <= t_in;
      acc_ff  <= acc_in;
      tq_ff   <= tq_in;
      w_ff    <= w_in;
      aa_ff   <= aa_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      len2_ff <= len2_in;
      len_ff  <= len_in;
      comp_ff <= comp_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         origin_ff      <= '0;
         direction_ff   <= '0;
         max_dist_ff    <= 32'hffff_ffff;
         min_det_ff     <= 16'd1678;
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         best_dist_ff   <= 32'hffff_ffff;
         found_ff       <= 1'b0;
         best_point_ff  <= '0;
         best_normal_ff <= '0;
         best_tri_ff    <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         origin_ff      <= origin_in;
         direction_ff   <= direction_in;
         max_dist_ff    <= max_dist_in;
         min_det_ff     <= min_det_in;
         state_ff       <= state_in;
         step_ff        <= step_in;
         best_dist_ff   <= best_dist_in;
         found_ff       <= found_in;
         best_point_ff  <= best_point_in;
         best_normal_ff <= best_normal_in;
         best_tri_ff    <= best_tri_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `RTNH_ASSERT_SAME(a_done_mark, rsp_valid, rsp_data.done_res, "result beat without done mark")
   `RTNH_ASSERT_SAME(a_miss_zero, rsp_valid && !rsp_data.hit, rsp_data.hit_distance == 0 && rsp_data.hit_index == 0 && rsp_data.hit_normal == 0, "miss beat carries hit data")
   `RTNH_ASSERT_SAME(a_div_free, div_cmd.start, !div_stat.busy, "divide started while busy")
   `RTNH_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_ff == ST_GEOM, "accepted beat did not start the product program")

endmodule

### verif/tb_top.sv
// Self-checking testbench of the ray/triangle nearest hit unit: scoreboard, stimulus and checks.
module tb_top;
   import rtnh_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_type       rsp_data;
   logic          csr_write;
   csr_index_type csr_index;
   logic [47:0]   csr_data;

   int  error_count = 0;
   bit  stim_done = 0;
   bit  hold_rsp = 0;
   int  idle_cycles = 0;

   ray_triangle_nearest_hit_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Predicts the mesh results and holds the ones still owed by the block
   class hit_scoreboard;
      logic [47:0] origin, direction;
      logic [31:0] max_dist;
      logic [15:0] min_det;
      logic [31:0] best_dist;
      bit          found;
      logic [47:0] best_pt, best_nrm;
      logic [15:0] best_tri, tri_count;
      rsp_type     pending[$];

      function new();
         origin = '0; direction = '0; max_dist = '1; min_det = 16'd1678;
         restart();
      endfunction

      function void restart();
         best_dist = max_dist; found = 0; best_pt = '0; best_nrm = '0;
         best_tri = '0; tri_count = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [47:0] val);
         case (idx)
            CSR_RAY_ORIGIN: origin = val;
            CSR_RAY_DIRECTION: direction = val;
            CSR_MAX_DISTANCE: begin
               max_dist = val[31:0];
               if (tri_count == 0) best_dist = max_dist;
            end
            default: min_det = val[15:0];
         endcase
      endfunction

      function longint signed part(logic [47:0] w, int i);
         return longint'($signed(w[16*i +: 16]));
      endfunction

      function longint signed floor_div64k(longint signed x);
         return x >>> 16;
      endfunction

      function logic [63:0] root(logic [63:0] x);
         logic [63:0] r, b;
         r = 0; b = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x -= r + b; r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function logic [47:0] blend_normal(req_type t, longint signed a, longint signed uu,
                                         longint signed vv);
         longint signed w0, wu, wv, c;
         logic [63:0] mag[3], mx, len2, len, m;
         bit          neg[3];
         logic [47:0] res;
         int          sh;
         sh = 0; mx = 0; len2 = 0; res = '0;
         while ((a >> sh) >= (64'd1 << 24)) sh++;
         w0 = (a - uu - vv) >> sh; wu = uu >> sh; wv = vv >> sh;
         for (int i = 0; i < 3; i++) begin
            c = w0 * part(t.normal_zero, i) + wu * part(t.normal_one, i)
                + wv * part(t.normal_two, i);
            neg[i] = c < 0;
            mag[i] = neg[i] ? -c : c;
            if (mag[i] > mx) mx = mag[i];
         end
         sh = 0;
         while ((mx >> sh) >= (64'd1 << 30)) sh++;
         for (int i = 0; i < 3; i++) begin
            mag[i] >>= sh;
            len2 += mag[i] * mag[i];
         end
         len = root(len2);
         if (len == 0) return '0;
         for (int i = 0; i < 3; i++) begin
            m = ((mag[i] << 15) + len) / (2 * len);
            if (m > 16384) m = 16384;
            res[16*i +: 16] = neg[i] ? 16'(-m) : 16'(m);
         end
         return res;
      endfunction

      // Run the intersection test and fold a nearer hit into the best one
      function void trace(req_type t);
         longint signed o[3], d[3], v0[3], e1[3], e2[3], s[3], p[3], q[3];
         longint signed a, uu, vv, tt, pc, thr;
         logic [63:0] ip, r, tq;
         logic [47:0] pt;
         for (int i = 0; i < 3; i++) begin
            o[i] = part(origin, i); d[i] = part(direction, i);
            v0[i] = part(t.vertex_zero, i);
            e1[i] = part(t.vertex_one, i) - v0[i];
            e2[i] = part(t.vertex_two, i) - v0[i];
            s[i] = o[i] - v0[i];
         end
         p[0] = d[1]*e2[2] - d[2]*e2[1]; p[1] = d[2]*e2[0] - d[0]*e2[2];
         p[2] = d[0]*e2[1] - d[1]*e2[0];
         a = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
         thr = longint'(min_det);
         if (a <= 0 || a < thr) return;
         uu = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
         if (uu < 0 || uu > a) return;
         q[0] = s[1]*e1[2] - s[2]*e1[1]; q[1] = s[2]*e1[0] - s[0]*e1[2];
         q[2] = s[0]*e1[1] - s[1]*e1[0];
         vv = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
         if (vv < 0 || uu + vv > a) return;
         tt = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
         if (tt <= 0) return;
         ip = tt / a;
         if (ip >= 65536) begin
            tq = 64'hFFFF_FFFF;
         end else begin
            r = tt % a; tq = ip;
            for (int i = 0; i < 16; i++) begin
               r <<= 1; tq <<= 1;
               if (r >= a) begin
                  r -= a; tq |= 1;
               end
            end
         end
         if (tq >= best_dist) return;
         for (int i = 0; i < 3; i++) begin
            pc = o[i] + floor_div64k(d[i] * longint'(tq));
            if (pc > 32767) pc = 32767;
            if (pc < -32768) pc = -32768;
            pt[16*i +: 16] = 16'(pc);
         end
         best_dist = tq[31:0]; found = 1; best_pt = pt;
         best_nrm = blend_normal(t, a, uu, vv);
         best_tri = tri_count;
      endfunction

      function void note_triangle(req_type t);
         rsp_type e;
         trace(t);
         tri_count = tri_count + 16'd1;
         if (!t.last_triangle) return;
         e.hit = found;
         e.hit_distance = found ? best_dist : '0;
         e.hit_point = found ? best_pt : '0;
         e.hit_normal = found ? best_nrm : '0;
         e.hit_index = found ? best_tri : '0;
         e.done_res = 1'b1;
         pending.push_back(e);
         restart();
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with no mesh outstanding");
            error_count++;
            return;
         end
         e = pending.pop_front();
         if (got.hit !== e.hit) begin
            $error("hit exp %0h got %0h", e.hit, got.hit); error_count++;
         end
         if (got.hit_distance !== e.hit_distance) begin
            $error("hit_distance exp %0h got %0h", e.hit_distance, got.hit_distance);
            error_count++;
         end
         if (got.hit_point !== e.hit_point) begin
            $error("hit_point exp %0h got %0h", e.hit_point, got.hit_point); error_count++;
         end
         if (got.hit_normal !== e.hit_normal) begin
            $error("hit_normal exp %0h got %0h", e.hit_normal, got.hit_normal);
            error_count++;
         end
         if (got.hit_index !== e.hit_index) begin
            $error("hit_index exp %0h got %0h", e.hit_index, got.hit_index); error_count++;
         end
         if (got.done_res !== e.done_res) begin
            $error("done_res exp %0h got %0h", e.done_res, got.done_res); error_count++;
         end
      endfunction
   endclass

   hit_scoreboard board = new();

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Pick a gap: mostly none or short, sometimes long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // Q7.8 vector built from small integer-ish components
   function automatic logic [47:0] near_vec(int span);
      logic [47:0] w;
      for (int i = 0; i < 3; i++)
         w[16*i +: 16] = 16'($signed($urandom_range(0, 2*span)) - span);
      return w;
   endfunction

   // Offer a beat until taken, then drop valid for one cycle
   task automatic send(req_type t);
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_triangle(t);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_gapped(req_type t);
      int g;
      g = gap_len();
      repeat (g) @(posedge clock);
      send(t);
   endtask

   task automatic write_reg(csr_index_type idx, logic [47:0] val);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   // Random triangle, mostly one that faces and straddles the ray
   function automatic req_type make_tri(bit last);
      req_type t;
      int      r;
      r = $urandom_range(0, 99);
      t.vertex_zero = near_vec(1024);
      t.vertex_one = near_vec(1024);
      t.vertex_two = near_vec(1024);
      if (r < 70) begin
         // x/y around the origin axis, z ahead of the ray; both windings
         t.vertex_zero = {16'($urandom_range(256, 6000)), 16'(-$urandom_range(1, 900)),
                          16'(-$urandom_range(1, 900))};
         t.vertex_one = {16'($urandom_range(256, 6000)), 16'(-$urandom_range(1, 900)),
                         16'($urandom_range(1, 900))};
         t.vertex_two = {16'($urandom_range(256, 6000)), 16'($urandom_range(1, 900)),
                         16'($urandom_range(0, 900))};
         if ($urandom_range(0, 3) == 0) begin
            logic [47:0] x;
            x = t.vertex_one; t.vertex_one = t.vertex_two; t.vertex_two = x;
         end
      end else if (r < 85) begin
         t.vertex_zero = 48'({$urandom, $urandom});
         t.vertex_one = 48'({$urandom, $urandom});
         t.vertex_two = 48'({$urandom, $urandom});
      end
      t.normal_zero = 48'({$urandom, $urandom});
      t.normal_one = 48'({$urandom, $urandom});
      t.normal_two = 48'({$urandom, $urandom});
      if ($urandom_range(0, 9) == 0) begin
         t.normal_zero = '0; t.normal_one = '0; t.normal_two = '0;
      end
      t.last_triangle = last;
      return t;
   endfunction

   // Random ray down +z from near the axis
   task automatic aim_ray();
      write_reg(CSR_RAY_ORIGIN, {16'($urandom_range(0, 200)), 16'($signed($urandom_range(0, 200)) - 100),
                                 16'($signed($urandom_range(0, 200)) - 100)});
      write_reg(CSR_RAY_DIRECTION, {16'($urandom_range(16, 1024)),
                                    16'($signed($urandom_range(0, 40)) - 20),
                                    16'($signed($urandom_range(0, 40)) - 20)});
   endtask

   // Receiver: random stalls, plus a long forced hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : ($urandom_range(0, 99) < 2);
      end
   end

   // Check each accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // Watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Long receiver hold counted in its own process
   initial begin
      wait (stim_done == 0);
      @(posedge clock);
      wait (board.pending.size() >= 1);
      hold_rsp = 1;
      repeat (3000) @(posedge clock);
      hold_rsp = 0;
   end

   initial begin
      req_type t;
      int      n, mesh;
      reset = 1; req_valid = 0; req_data = '0;
      csr_write = 0; csr_index = CSR_RAY_ORIGIN; csr_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, extremes, culls, zero normals, wide fields
      t = '0; t.last_triangle = 1; send(t);
      t = '1; send(t);
      t = make_tri(0); t.vertex_zero = 48'h8000_8000_8000; send(t);
      t = make_tri(1); t.normal_zero = 48'h7FFF_7FFF_7FFF; send(t);
      drain();
      write_reg(CSR_MIN_DETERMINANT, 48'd0);
      write_reg(CSR_MAX_DISTANCE, 48'hFFFF_FFFF);
      aim_ray();
      for (int i = 0; i < 6; i++) send(make_tri(i == 5));
      t = make_tri(0); t.vertex_one = t.vertex_zero; t.vertex_two = t.vertex_zero; send(t);
      t = make_tri(1); t.normal_zero = '0; t.normal_one = '0; t.normal_two = '0; send(t);
      drain();
      write_reg(CSR_MIN_DETERMINANT, 48'hFFFF);
      write_reg(CSR_MAX_DISTANCE, 48'd0);
      for (int i = 0; i < 4; i++) send(make_tri(i == 3));
      drain();
      write_reg(CSR_RAY_ORIGIN, 48'h8000_7FFF_FFFF);
      write_reg(CSR_RAY_DIRECTION, 48'h7FFF_8000_0001);
      write_reg(CSR_MAX_DISTANCE, 48'h0001_0000);
      for (int i = 0; i < 3; i++) send(make_tri(i == 2));
      drain();

      // Random meshes under changing settings
      n = 0; mesh = 0;
      while (n < 650) begin
         if (mesh % 12 == 0) begin
            drain();
            aim_ray();
            case ($urandom_range(0, 3))
               0: write_reg(CSR_MIN_DETERMINANT, 48'd0);
               1: write_reg(CSR_MIN_DETERMINANT, 48'hFFFF);
               default: write_reg(CSR_MIN_DETERMINANT, 48'($urandom_range(0, 4000)));
            endcase
            case ($urandom_range(0, 3))
               0: write_reg(CSR_MAX_DISTANCE, 48'hFFFF_FFFF);
               1: write_reg(CSR_MAX_DISTANCE, 48'($urandom));
               default: write_reg(CSR_MAX_DISTANCE, 48'($urandom_range(1, 32'h20_0000)));
            endcase
         end
         if (mesh == 30) drain();
         for (int k = $urandom_range(1, 6); k > 0; k--) begin
            send_gapped(make_tri(k == 1));
            n++;
         end
         mesh++;
      end

      stim_done = 1;
      drain();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
